[rtl/nbd_pkg.sv]
// ----------------------------------------------------------------------------
// Negative-base digit converter package
// Shared widths, limits and the request/response bundles of the divider.
// ----------------------------------------------------------------------------
`default_nettype none

package nbd_pkg;

  localparam int VALUE_W    = 64;
  localparam int BASE_W     = 9;
  localparam int DIGIT_W    = 8;
  localparam int POS_W      = 6;
  localparam int MAX_DIGITS = 64;
  localparam int STEP_W     = 6;   // counts VALUE_W divider steps

  localparam logic [BASE_W-1:0] BASE_MIN   = BASE_W'(2);
  localparam logic [BASE_W-1:0] BASE_MAX   = BASE_W'(256);
  localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(2);

  // Request towards the divider
  typedef struct packed {
    logic                start;
    logic [VALUE_W-1:0]  dividend;
    logic [BASE_W-1:0]   divisor;
  } div_req_t;

  // Response from the divider
  typedef struct packed {
    logic                done;
    logic [VALUE_W-1:0]  quotient;
    logic [BASE_W-1:0]   remainder;
  } div_rsp_t;

  // Clamp the raw register into the legal base range
  function automatic logic [BASE_W-1:0] eff_base(input logic [BASE_W-1:0] raw);
    logic [BASE_W-1:0] b;
    b = raw;
    if (raw < BASE_MIN) b = BASE_MIN;
    if (raw > BASE_MAX) b = BASE_MAX;
    return b;
  endfunction

endpackage

`default_nettype wire

[rtl/nbd_div.sv]
// ----------------------------------------------------------------------------
// Bit-serial unsigned divider
// Restoring division of a 64-bit magnitude by a 9-bit base, one quotient bit
// per cycle; done pulses once quotient and remainder are final.
// ----------------------------------------------------------------------------
`default_nettype none

module nbd_div (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire nbd_pkg::div_req_t req,
  output nbd_pkg::div_rsp_t    rsp
);

  logic                          run_r, run_nxt;
  logic                          done_r, done_nxt;
  logic [nbd_pkg::STEP_W-1:0]    cnt_r, cnt_nxt;
  logic [nbd_pkg::VALUE_W-1:0]   dq_r, dq_nxt;
  logic [nbd_pkg::BASE_W-1:0]    rem_r, rem_nxt;
  logic [nbd_pkg::BASE_W-1:0]    div_r, div_nxt;
  logic [nbd_pkg::BASE_W:0]      rem_sh;
  logic                          ge;

  // Shift in the next dividend bit and trial-subtract the divisor
  assign rem_sh = {rem_r, dq_r[nbd_pkg::VALUE_W-1]};
  assign ge     = (rem_sh >= {1'b0, div_r});

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dq_nxt   = dq_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (req.start) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      dq_nxt  = req.dividend;
      rem_nxt = '0;
      div_nxt = req.divisor;
    end else if (run_r) begin
      rem_nxt = ge ? nbd_pkg::BASE_W'(rem_sh - {1'b0, div_r})
                   : rem_sh[nbd_pkg::BASE_W-1:0];
      dq_nxt  = {dq_r[nbd_pkg::VALUE_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == nbd_pkg::STEP_W'(nbd_pkg::VALUE_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = dq_r;
  assign rsp.remainder = rem_r;

  // Completion follows the final step of a run
  a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(run_r)) else $error("divider done without a run");

  // Remainder is always reduced below the divisor on completion
  a_rem_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (rem_r < div_r)) else $error("divider remainder not reduced");

  // No overlapping runs and completion
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !run_r) else $error("divider still running when done");

endmodule

`default_nettype wire

[rtl/signed_to_negative_base_digits_unit.sv]
// ----------------------------------------------------------------------------
// Signed to negative-base digit converter
// Per digit: a launch state, then a bit-serial divide in nbd_div, then a
//   registered emit; the next digit launches when the emit is decided.
//   An item yields up to 64 digits, one after another.
// Throughput: one item at a time; busy stays high until the last digit.
// Results cannot be stalled: each digit is shown for one cycle on out_valid.
// Reset: synchronous active-low rst_n; base returns to 2, sequencer to idle.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_to_negative_base_digits_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input transaction
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [nbd_pkg::VALUE_W-1:0]   in_value,
  // result transaction
  output logic                               out_valid,
  output logic [nbd_pkg::DIGIT_W-1:0]        out_digit,
  output logic [nbd_pkg::POS_W-1:0]          out_digit_position,
  output logic                               out_last_digit,
  // configuration
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [nbd_pkg::BASE_W-1:0]    cfg_data
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_LAUNCH = 2'd1;
  localparam logic [1:0] ST_WAIT   = 2'd2;

  logic [1:0]                    state_r, state_nxt;
  logic [nbd_pkg::BASE_W-1:0]    base_r;
  logic [nbd_pkg::VALUE_W-1:0]   q_r, q_nxt;
  logic [nbd_pkg::POS_W-1:0]     pos_r, pos_nxt;
  logic                          ov_r, ov_nxt;
  logic [nbd_pkg::DIGIT_W-1:0]   od_r, od_nxt;
  logic [nbd_pkg::POS_W-1:0]     op_r, op_nxt;
  logic                          ol_r, ol_nxt;

  nbd_pkg::div_req_t             req;
  nbd_pkg::div_rsp_t             rsp;

  logic                          neg;
  logic [nbd_pkg::BASE_W-1:0]    b_eff;
  logic                          rnz;
  logic [nbd_pkg::BASE_W-1:0]    r;
  logic [nbd_pkg::VALUE_W-1:0]   q_new;
  logic                          last;

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = !busy;

  // Base register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= nbd_pkg::BASE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      base_r <= cfg_data;
    end
  end

  assign b_eff = nbd_pkg::eff_base(base_r);
  assign neg   = q_r[nbd_pkg::VALUE_W-1];

  // Divide the magnitude of the current quotient by the base
  assign req.start    = (state_r == ST_LAUNCH);
  assign req.dividend = neg ? (~q_r + 1'b1) : q_r;
  assign req.divisor  = b_eff;

  nbd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  // Force the digit non-negative and form the exact next quotient
  assign rnz   = (rsp.remainder != '0);
  assign r     = (neg && rnz) ? nbd_pkg::BASE_W'(b_eff - rsp.remainder) : rsp.remainder;
  assign q_new = neg ? (rsp.quotient + nbd_pkg::VALUE_W'(rnz))
                     : (~rsp.quotient + 1'b1);
  assign last  = (q_new == '0) ||
                 (pos_r == nbd_pkg::POS_W'(nbd_pkg::MAX_DIGITS - 1));

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    q_nxt     = q_r;
    pos_nxt   = pos_r;
    ov_nxt    = 1'b0;
    od_nxt    = od_r;
    op_nxt    = op_r;
    ol_nxt    = ol_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          q_nxt     = in_value;
          pos_nxt   = '0;
          state_nxt = ST_LAUNCH;
        end
      end
      ST_LAUNCH: begin
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (rsp.done) begin
          ov_nxt  = 1'b1;
          od_nxt  = r[nbd_pkg::DIGIT_W-1:0];
          op_nxt  = pos_r;
          ol_nxt  = last;
          q_nxt   = q_new;
          pos_nxt = pos_r + 1'b1;
          state_nxt = last ? ST_IDLE : ST_LAUNCH;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
      q_r     <= '0;
      pos_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      q_r     <= q_nxt;
      pos_r   <= pos_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    od_r <= od_nxt;
    op_r <= op_nxt;
    ol_r <= ol_nxt;
  end

  assign out_valid          = ov_r;
  assign out_digit          = od_r;
  assign out_digit_position = op_r;
  assign out_last_digit     = ol_r;

  // A digit is only emitted on divider completion
  a_emit_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> $past(rsp.done)) else $error("digit emitted without division");

  // Final digit returns the sequencer to idle
  a_last_idles: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && ol_r) |-> !busy) else $error("busy after final digit");

  // An accepted transaction starts a divide on the next cycle
  a_start_launch: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> req.start) else $error("accepted item not launched");

endmodule

`default_nettype wire

[dv/tb.sv]
// ----------------------------------------------------------------------------
// Negative-base digit converter testbench
// Sends signed 64-bit values through the start/busy port under a series of
// base settings, predicts the base minus b digits of each accepted value and
// checks every digit strobe, in order, against the predicted digit, position
// and last-digit flag.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import nbd_pkg::*;

  // Worst case is about 335 values of 64 digits each plus gaps; the limit
  // allows several times that.
  localparam int CYCLE_LIMIT = 8_000_000;
  localparam int TAIL_CYCLES = 200;
  localparam int REPORT_MAX  = 10;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic [POS_W-1:0]   pos;
    logic               last;
  } digit_t;

  typedef struct {
    logic [VALUE_W-1:0] value;
    int                 gap;
    bit                 drain_first;
  } value_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic [VALUE_W-1:0] in_value = '0;
  logic cfg_valid = 1'b0;
  logic [BASE_W-1:0] cfg_data = '0;
  logic busy;
  logic out_valid;
  logic [DIGIT_W-1:0] out_digit;
  logic [POS_W-1:0] out_digit_position;
  logic out_last_digit;
  logic cfg_ready;

  value_item_t values_to_send[$];
  digit_t digits_due[$];
  logic [BASE_W-1:0] base_shadow = BASE_RESET;
  value_item_t next_item;
  bit holding = 1'b0;
  int gap_left = 0;
  int mismatches = 0;
  int cycle_count = 0;

  signed_to_negative_base_digits_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_value           (in_value),
    .out_valid          (out_valid),
    .out_digit          (out_digit),
    .out_digit_position (out_digit_position),
    .out_last_digit     (out_last_digit),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_data           (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Work out the base minus b digits of one value, least significant first
  function automatic void convert_to_neg_base(input logic [VALUE_W-1:0] value);
    logic [VALUE_W-1:0] b;
    logic [VALUE_W-1:0] q;
    logic [VALUE_W-1:0] m;
    logic [VALUE_W-1:0] r;
    digit_t d;
    int n;
    bit finished;
    b = VALUE_W'(base_shadow);
    if (b < 2) b = 2;
    if (b > 256) b = 256;
    q = value;
    n = 0;
    finished = 1'b0;
    while (!finished) begin
      if (!q[VALUE_W-1]) begin
        // non-negative: quotient is minus the plain quotient
        m = q;
        r = m % b;
        q = -((m - r) / b);
      end else begin
        // negative: work on the magnitude, pull the remainder up to 0..b-1
        m = -q;
        r = m % b;
        if (r != 0) r = b - r;
        q = (m + r) / b;
      end
      d.digit = r[DIGIT_W-1:0];
      d.pos = n[POS_W-1:0];
      n++;
      finished = (q == 0) || (n == MAX_DIGITS);
      d.last = finished;
      digits_due.push_back(d);
    end
  endfunction

  task automatic report_error(input string msg);
    mismatches++;
    if (mismatches <= REPORT_MAX) $display("tb: mismatch: %s", msg);
  endtask

  // Drive start and value; predict each transaction as it is taken
  always @(posedge clk) begin : drive_proc
    bit taken;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      taken = start && !busy;
      if (taken) begin
        convert_to_neg_base(in_value);
      end
      if (taken || !start) begin
        if (!holding && values_to_send.size() > 0) begin
          next_item = values_to_send.pop_front();
          holding = 1'b1;
          gap_left = next_item.gap;
        end
        if (holding && gap_left == 0 &&
            !(next_item.drain_first && digits_due.size() > 0)) begin
          start <= 1'b1;
          in_value <= next_item.value;
          holding = 1'b0;
        end else begin
          start <= 1'b0;
          if (holding && gap_left > 0) gap_left--;
        end
      end
    end
  end

  // Compare each digit strobe with the oldest predicted digit
  always @(posedge clk) begin : monitor_proc
    digit_t want;
    if (rst_n && out_valid) begin
      if (digits_due.size() == 0) begin
        report_error($sformatf("unexpected digit %0d pos %0d last %0b",
                               out_digit, out_digit_position, out_last_digit));
      end else begin
        want = digits_due.pop_front();
        if (out_digit !== want.digit || out_digit_position !== want.pos ||
            out_last_digit !== want.last) begin
          report_error($sformatf("got digit %0d pos %0d last %0b, want %0d pos %0d last %0b",
                                 out_digit, out_digit_position, out_last_digit,
                                 want.digit, want.pos, want.last));
        end
      end
    end
  end

  // Count cycles and stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  task automatic queue_value(input logic [VALUE_W-1:0] v, input bit no_gap,
                             input bit drain);
    value_item_t it;
    it.value = v;
    it.gap = no_gap ? 0 : $urandom_range(0, 6);
    it.drain_first = drain;
    values_to_send.push_back(it);
  endtask

  // Wait on the falling edge until nothing is queued, in flight or due
  task automatic settle();
    @(negedge clk);
    while (values_to_send.size() > 0 || holding || start || digits_due.size() > 0 || busy)
      @(negedge clk);
  endtask

  // Write the base register once the block has gone idle
  task automatic write_base(input logic [BASE_W-1:0] raw);
    settle();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= raw;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    base_shadow = raw;
  endtask

  // Mostly short values to keep the run quick, some full width
  function automatic logic [VALUE_W-1:0] draw_value();
    logic [VALUE_W-1:0] raw;
    int nbits;
    raw = {$urandom, $urandom};
    if ($urandom_range(0, 9) < 2) return raw;
    nbits = $urandom_range(1, 20);
    raw = raw & ((64'd1 << nbits) - 64'd1);
    if ($urandom_range(0, 1) == 1) raw = -raw;
    return raw;
  endfunction

  initial begin : sequence_proc
    logic [BASE_W-1:0] phase_bases[11];
    logic [BASE_W-1:0] raw;
    int p;
    int k;
    bit no_gap;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset base: small values, range ends, most negative, digit limit overrun
    queue_value(64'd0, 1'b0, 1'b0);
    queue_value(64'd1, 1'b0, 1'b0);
    queue_value(-64'd1, 1'b0, 1'b0);
    queue_value(64'd2, 1'b0, 1'b0);
    queue_value(-64'd2, 1'b0, 1'b0);
    queue_value(64'd3, 1'b0, 1'b0);
    queue_value(64'h5555_5555_5555_5555, 1'b0, 1'b0);
    queue_value(64'h8000_0000_0000_0100, 1'b0, 1'b0);
    queue_value(64'h8000_0000_0000_0000, 1'b0, 1'b0);
    queue_value(64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 1'b0);

    // Base below range acts as 2
    write_base(9'd0);
    queue_value(64'd6, 1'b0, 1'b0);
    queue_value(-64'd7, 1'b0, 1'b0);
    write_base(9'd1);
    queue_value(64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 1'b0);

    // Base above range acts as 256; then bases 256 and 3 directly
    write_base(9'd511);
    queue_value(64'd255, 1'b0, 1'b0);
    queue_value(-64'd255, 1'b0, 1'b0);
    queue_value(64'd256, 1'b0, 1'b0);
    queue_value(-64'd256, 1'b0, 1'b0);
    queue_value(64'h8000_0000_0000_0000, 1'b0, 1'b0);
    queue_value(64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 1'b0);
    write_base(9'd257);
    queue_value(-64'd1, 1'b0, 1'b0);
    write_base(9'd256);
    queue_value(64'hFFFF_FFFF_FFFF_FF00, 1'b0, 1'b0);
    write_base(9'd3);
    queue_value(64'd4, 1'b0, 1'b0);
    queue_value(-64'd4, 1'b0, 1'b0);

    // Random phases across the base range, clamped settings included
    phase_bases = '{9'd2, 9'd256, 9'd3, 9'd0, 9'd10, 9'd511, 9'd16, 9'd255, 9'd1,
                    9'd7, 9'd0};
    phase_bases[10] = BASE_W'($urandom_range(0, 511));
    for (p = 0; p < 11; p++) begin
      raw = phase_bases[p];
      write_base(raw);
      no_gap = (p % 4 == 1);
      for (k = 0; k < 28; k++) begin
        queue_value(draw_value(), no_gap, (p % 2 == 0) && (k == 14));
      end
    end

    // Drain, let any stray strobe show, then report
    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && digits_due.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
